// ----- rtl/pfp_pkg.sv -----
// Shared types, codes and constants of the pose frame parser.
package pfp_pkg;

  // item opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam logic CFG_OVERFLOW_LIMIT = 1'b0;
  localparam logic CFG_LOST_TIMEOUT   = 1'b1;

  // link status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_LOST     = 2'd2;

  // framing bytes
  localparam logic [7:0] SYNC_A    = 8'hAA;
  localparam logic [7:0] SYNC_B    = 8'hFF;
  localparam logic [7:0] POSE_CODE = 8'hA1;
  localparam logic [7:0] TRAILER   = 8'h00;

  localparam int POSE_BYTES_DEF = 18;
  localparam int LEN_LIMIT_DEF  = 250;
  localparam int POSE_WORDS     = 9;
  localparam logic [1:0] REJECT_ERR = 2'd2;

  localparam logic [15:0] OVERFLOW_LIMIT_RST = 16'd32768;
  localparam logic [15:0] LOST_TIMEOUT_RST   = 16'd1000;

  typedef logic [POSE_WORDS-1:0][15:0] pose_vec_t;

  typedef struct packed {
    logic       pose_updated;
    logic       offline;
    logic [1:0] link_status;
    pose_vec_t  pose;
  } pfp_result_t;

  // absolute value of a two's complement word, 0x8000 gives 32768
  function automatic logic [16:0] magnitude(input logic [15:0] v);
    logic [16:0] m;
    if (v[15]) begin
      m = 17'h10000 - {1'b0, v};
    end else begin
      m = {1'b0, v};
    end
    return m;
  endfunction

endpackage

// ----- rtl/pose_frame_parser_with_link_watchdog.sv -----
// Top level: serial pose frame parser, pose check and lost-link watchdog.
// One word is taken per clock unless stalled, either a received byte or a
// millisecond tick, and each yields exactly one result word. All parsing, the
// pose range check and the timer update are done in a single registered pass,
// so the rate is one word per cycle with no bubbles if out_stall is low. A
// two-entry output buffer (result register plus skid register) lets a new
// word enter while a result waits; in_stall rises only when both are full.
// Configuration writes are taken at any time and should be made while idle.
module pose_frame_parser_with_link_watchdog #(
  parameter int POSE_BYTES = pfp_pkg::POSE_BYTES_DEF,
  parameter int LEN_LIMIT  = pfp_pkg::LEN_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [7:0]         in_rx_byte,
  input  logic [7:0]         in_tick_ms,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_pose_updated,
  output logic               out_offline,
  output logic [1:0]         out_link_status,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic signed [15:0] out_vel_x,
  output logic signed [15:0] out_vel_y,
  output logic signed [15:0] out_vel_z,
  // configuration port
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int IDX_W  = $clog2(POSE_BYTES + 1);
  localparam int ADDR_W = $clog2(POSE_BYTES);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SYNC = 3'd1;
  localparam logic [2:0] PH_ADDR = 3'd2;
  localparam logic [2:0] PH_FUNC = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_TAIL = 3'd5;

  // configuration
  logic [15:0] ovf_limit_r;
  logic [15:0] lost_timeout_r;

  // parser and watchdog state
  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       remain_r, remain_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             func_pose_r, func_pose_nxt;
  logic [1:0]       reject_r, reject_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [15:0]      timer_r, timer_nxt;
  logic             offline_r, offline_nxt;
  pfp_pkg::pose_vec_t pose_r, pose_nxt;
  logic [7:0]       store_r [POSE_BYTES];

  logic             store_we;
  logic             accepted;
  logic             take;
  pfp_pkg::pfp_result_t res;

  // output buffer
  logic                 out_valid_r;
  pfp_pkg::pfp_result_t out_data_r;
  logic                 skid_valid_r;
  pfp_pkg::pfp_result_t skid_data_r;

  pfp_pkg::pose_vec_t words;
  logic               in_range;
  logic [1:0]         reject_inc;
  logic [16:0]        timer_sum;

  assign take      = in_valid && !in_stall;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int k = 0; k < pfp_pkg::POSE_WORDS; k++) begin
      words[k] = {store_r[2*k], store_r[2*k+1]};
    end
    in_range = (pfp_pkg::magnitude(words[0]) < {1'b0, ovf_limit_r}) &&
               (pfp_pkg::magnitude(words[1]) < {1'b0, ovf_limit_r}) &&
               (pfp_pkg::magnitude(words[2]) < {1'b0, ovf_limit_r});
    reject_inc = (reject_r == 2'd3) ? reject_r : reject_r + 2'd1;
    timer_sum  = {1'b0, timer_r} + {9'd0, in_tick_ms};
  end

  always_comb begin
    phase_nxt     = phase_r;
    remain_nxt    = remain_r;
    idx_nxt       = idx_r;
    func_pose_nxt = func_pose_r;
    reject_nxt    = reject_r;
    status_nxt    = status_r;
    timer_nxt     = timer_r;
    offline_nxt   = offline_r;
    pose_nxt      = pose_r;
    store_we      = 1'b0;
    accepted      = 1'b0;

    if (in_opcode == pfp_pkg::OP_BYTE) begin
      unique case (phase_r)
        PH_IDLE: begin
          phase_nxt = (in_rx_byte == pfp_pkg::SYNC_A) ? PH_SYNC : PH_IDLE;
        end
        PH_SYNC: begin
          phase_nxt = (in_rx_byte == pfp_pkg::SYNC_B) ? PH_ADDR : PH_IDLE;
        end
        PH_ADDR: begin
          func_pose_nxt = (in_rx_byte == pfp_pkg::POSE_CODE);
          phase_nxt     = PH_FUNC;
        end
        PH_FUNC: begin
          if ({1'b0, in_rx_byte} < 9'(LEN_LIMIT)) begin
            remain_nxt = in_rx_byte;
            idx_nxt    = '0;
            phase_nxt  = (in_rx_byte == 8'd0) ? PH_TAIL : PH_DATA;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_DATA: begin
          if (idx_r < IDX_W'(POSE_BYTES)) begin
            store_we = 1'b1;
            idx_nxt  = idx_r + 1'b1;
          end
          if (remain_r != 8'd0) begin
            remain_nxt = remain_r - 8'd1;
          end
          if (remain_nxt == 8'd0) begin
            phase_nxt = PH_TAIL;
          end
        end
        PH_TAIL: begin
          if (in_rx_byte == pfp_pkg::TRAILER) begin
            if (func_pose_r && (idx_r >= IDX_W'(POSE_BYTES))) begin
              if (in_range) begin
                pose_nxt   = words;
                status_nxt = pfp_pkg::ST_OK;
                reject_nxt = 2'd0;
                accepted   = 1'b1;
              end else begin
                reject_nxt = reject_inc;
                if (reject_inc >= pfp_pkg::REJECT_ERR) begin
                  status_nxt = pfp_pkg::ST_OVERFLOW;
                end
              end
            end
            timer_nxt   = 16'd0;
            offline_nxt = 1'b0;
          end
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end else begin
      if (timer_r < lost_timeout_r) begin
        timer_nxt = timer_sum[16] ? 16'hFFFF : timer_sum[15:0];
      end else begin
        offline_nxt = 1'b1;
        status_nxt  = pfp_pkg::ST_LOST;
      end
    end

    res.pose_updated = accepted;
    res.offline      = offline_nxt;
    res.link_status  = status_nxt;
    res.pose         = pose_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_limit_r    <= pfp_pkg::OVERFLOW_LIMIT_RST;
      lost_timeout_r <= pfp_pkg::LOST_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pfp_pkg::CFG_OVERFLOW_LIMIT: ovf_limit_r    <= cfg_data;
        pfp_pkg::CFG_LOST_TIMEOUT:   lost_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      remain_r    <= 8'd0;
      idx_r       <= '0;
      func_pose_r <= 1'b0;
      reject_r    <= 2'd0;
      status_r    <= pfp_pkg::ST_OK;
      timer_r     <= 16'd0;
      offline_r   <= 1'b0;
      pose_r      <= '0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      remain_r    <= remain_nxt;
      idx_r       <= idx_nxt;
      func_pose_r <= func_pose_nxt;
      reject_r    <= reject_nxt;
      status_r    <= status_nxt;
      timer_r     <= timer_nxt;
      offline_r   <= offline_nxt;
      pose_r      <= pose_nxt;
    end
  end

  // payload bytes, only the first POSE_BYTES of a frame are kept
  always_ff @(posedge clk) begin
    if (take && store_we) begin
      store_r[idx_r[ADDR_W-1:0]] <= in_rx_byte;
    end
  end

  // result register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= take;
      end
    end else if (take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (take) begin
      skid_data_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pose_updated = out_data_r.pose_updated;
  assign out_offline      = out_data_r.offline;
  assign out_link_status  = out_data_r.link_status;
  assign out_pos_x        = $signed(out_data_r.pose[0]);
  assign out_pos_y        = $signed(out_data_r.pose[1]);
  assign out_pos_z        = $signed(out_data_r.pose[2]);
  assign out_roll_angle   = $signed(out_data_r.pose[3]);
  assign out_pitch_angle  = $signed(out_data_r.pose[4]);
  assign out_yaw_angle    = $signed(out_data_r.pose[5]);
  assign out_vel_x        = $signed(out_data_r.pose[6]);
  assign out_vel_y        = $signed(out_data_r.pose[7]);
  assign out_vel_z        = $signed(out_data_r.pose[8]);

  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty result register");

  // offline is only set with lost status and cleared by a frame's trailer byte
  a_offline_lost: assert property (@(posedge clk) disable iff (!rst_n)
    offline_r |-> (status_r == pfp_pkg::ST_LOST))
    else $error("offline flag without lost status");

  // data phase always has bytes left to take
  a_data_remain: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (remain_r != 8'd0))
    else $error("data phase with no bytes remaining");

  // an accepted pose always reports ok status
  a_pose_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (take && accepted) |=> (status_r == pfp_pkg::ST_OK) && !offline_r)
    else $error("accepted pose left status not ok");

endmodule
